@@ rtl/mck_pkg.sv @@
// morse code keyer package: phase codes, register indexes, reset durations
// and the letter code table; no dependencies
package mck_pkg;

  localparam int unsigned DUR_WIDTH     = 16;
  localparam int unsigned CFG_IDX_WIDTH = 3;
  localparam int unsigned COUNT_WIDTH_DEFAULT = 16;

  localparam logic [DUR_WIDTH-1:0] DOT_TICKS_RST  = 16'd100;
  localparam logic [DUR_WIDTH-1:0] DASH_TICKS_RST = 16'd300;
  localparam logic [DUR_WIDTH-1:0] EGAP_TICKS_RST = 16'd100;
  localparam logic [DUR_WIDTH-1:0] LGAP_TICKS_RST = 16'd300;
  localparam logic [DUR_WIDTH-1:0] WGAP_TICKS_RST = 16'd700;

  localparam logic [CFG_IDX_WIDTH-1:0] REG_DOT_TICKS  = 3'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_DASH_TICKS = 3'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_EGAP_TICKS = 3'd2;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_LGAP_TICKS = 3'd3;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_WGAP_TICKS = 3'd4;

  localparam logic OP_CHAR = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CASE_BIT     = 8'h20;

  typedef enum logic [1:0] {
    PH_MARK = 2'd0,
    PH_EGAP = 2'd1,
    PH_LGAP = 2'd2,
    PH_WGAP = 2'd3
  } phase_e;

  typedef struct packed {
    logic [2:0] length;
    logic [3:0] pattern;
  } letter_code_t;

  // bit i of the pattern set means element i is a dash
  function automatic letter_code_t letter_code(input logic [4:0] idx);
    logic [7:0] c;
    case (idx)
      5'd0:  c = 8'h22;
      5'd1:  c = 8'h41;
      5'd2:  c = 8'h45;
      5'd3:  c = 8'h31;
      5'd4:  c = 8'h10;
      5'd5:  c = 8'h44;
      5'd6:  c = 8'h33;
      5'd7:  c = 8'h40;
      5'd8:  c = 8'h20;
      5'd9:  c = 8'h4E;
      5'd10: c = 8'h35;
      5'd11: c = 8'h42;
      5'd12: c = 8'h23;
      5'd13: c = 8'h21;
      5'd14: c = 8'h37;
      5'd15: c = 8'h46;
      5'd16: c = 8'h4B;
      5'd17: c = 8'h32;
      5'd18: c = 8'h30;
      5'd19: c = 8'h11;
      5'd20: c = 8'h34;
      5'd21: c = 8'h48;
      5'd22: c = 8'h36;
      5'd23: c = 8'h49;
      5'd24: c = 8'h4D;
      5'd25: c = 8'h43;
      default: c = 8'h00;
    endcase
    letter_code.length  = c[6:4];
    letter_code.pattern = c[3:0];
  endfunction

endpackage

@@ rtl/morse_code_keyer.sv @@
// morse code keyer top level: character and tick items in, one status item out
// per input item; depends on mck_pkg
// result: the status item of each accepted item is registered in the output register
// throughput: one item per cycle, limited only by the single-entry output register
// reset: asynchronous, active low; keyer idle, led dark, durations at their defaults
module morse_code_keyer #(
  parameter int unsigned COUNT_WIDTH = mck_pkg::COUNT_WIDTH_DEFAULT
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  logic [7:0]                         s_axis_tdata_i,   // character
  input  logic                               s_axis_tuser_i,   // operation
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  output logic [7:0]                         m_axis_tdata_o,   // led_on, busy_res, accepted,
                                                               // done_res, zero fill
  input  logic                               cfg_we_i,
  input  logic [mck_pkg::CFG_IDX_WIDTH-1:0]  cfg_idx_i,
  input  logic [mck_pkg::DUR_WIDTH-1:0]      cfg_data_i
);
  import mck_pkg::*;

  localparam int unsigned EW = ((COUNT_WIDTH > DUR_WIDTH) ? COUNT_WIDTH : DUR_WIDTH) + 1;
  localparam logic [EW-1:0] CNT_MAX = {{(EW-COUNT_WIDTH){1'b0}}, {COUNT_WIDTH{1'b1}}};
  localparam logic [EW-1:0] ONE_EXT = {{(EW-1){1'b0}}, 1'b1};

  logic [DUR_WIDTH-1:0] dot_ticks_q, dash_ticks_q, egap_ticks_q, lgap_ticks_q, wgap_ticks_q;

  logic                   active_q, active_d;
  logic [3:0]             pattern_q, pattern_d;
  logic [2:0]             length_q, length_d;
  logic [2:0]             elem_idx_q, elem_idx_d;
  phase_e                 phase_q, phase_d;
  logic [COUNT_WIDTH-1:0] tick_cnt_q, tick_cnt_d;
  logic                   lamp_q, lamp_d;
  logic                   acc_d, done_d;

  logic                   out_valid_q;
  logic [3:0]             out_data_q;

  logic                   in_fire;
  logic [7:0]             lc;
  letter_code_t           code;
  logic [DUR_WIDTH-1:0]   dur;
  logic [EW-1:0]          dur_ext, dur_sat, next_ext;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'b0000, out_data_q};

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_ticks_q  <= DOT_TICKS_RST;
      dash_ticks_q <= DASH_TICKS_RST;
      egap_ticks_q <= EGAP_TICKS_RST;
      lgap_ticks_q <= LGAP_TICKS_RST;
      wgap_ticks_q <= WGAP_TICKS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_DOT_TICKS:  dot_ticks_q  <= cfg_data_i;
        REG_DASH_TICKS: dash_ticks_q <= cfg_data_i;
        REG_EGAP_TICKS: egap_ticks_q <= cfg_data_i;
        REG_LGAP_TICKS: lgap_ticks_q <= cfg_data_i;
        REG_WGAP_TICKS: wgap_ticks_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // case folding and table lookup
  always_comb begin
    lc = s_axis_tdata_i;
    if (lc >= CHAR_UPPER_A && lc <= CHAR_UPPER_Z) begin
      lc = lc | CASE_BIT;
    end
    code = letter_code(5'(lc - CHAR_LOWER_A));
  end

  // duration of the current phase, at least one tick, clipped to the counter
  always_comb begin
    case (phase_q)
      PH_MARK: dur = pattern_q[elem_idx_q[1:0]] ? dash_ticks_q : dot_ticks_q;
      PH_EGAP: dur = egap_ticks_q;
      PH_LGAP: dur = lgap_ticks_q;
      PH_WGAP: dur = wgap_ticks_q;
      default: dur = wgap_ticks_q;
    endcase
    dur_ext = EW'(dur);
    dur_sat = (dur_ext > CNT_MAX) ? CNT_MAX : dur_ext;
    if (dur_ext == '0) begin
      dur_sat = ONE_EXT;
    end
    next_ext = EW'(tick_cnt_q) + ONE_EXT;
  end

  always_comb begin
    active_d   = active_q;
    pattern_d  = pattern_q;
    length_d   = length_q;
    elem_idx_d = elem_idx_q;
    phase_d    = phase_q;
    tick_cnt_d = tick_cnt_q;
    lamp_d     = lamp_q;
    acc_d      = 1'b0;
    done_d     = 1'b0;
    if (s_axis_tuser_i == OP_CHAR) begin
      if (!active_q) begin
        if (lc >= CHAR_LOWER_A && lc <= CHAR_LOWER_Z) begin
          pattern_d  = code.pattern;
          length_d   = code.length;
          elem_idx_d = '0;
          phase_d    = PH_MARK;
          tick_cnt_d = '0;
          lamp_d     = 1'b1;
          active_d   = 1'b1;
          acc_d      = 1'b1;
        end else if (lc == CHAR_SPACE) begin
          pattern_d  = '0;
          length_d   = '0;
          elem_idx_d = '0;
          phase_d    = PH_WGAP;
          tick_cnt_d = '0;
          lamp_d     = 1'b0;
          active_d   = 1'b1;
          acc_d      = 1'b1;
        end
      end
    end else if (active_q) begin
      if (next_ext >= dur_sat) begin
        tick_cnt_d = '0;
        case (phase_q)
          PH_MARK: begin
            lamp_d  = 1'b0;
            phase_d = ({1'b0, elem_idx_q} + 4'd1 < {1'b0, length_q}) ? PH_EGAP : PH_LGAP;
          end
          PH_EGAP: begin
            elem_idx_d = elem_idx_q + 3'd1;
            phase_d    = PH_MARK;
            lamp_d     = 1'b1;
          end
          default: begin
            active_d   = 1'b0;
            lamp_d     = 1'b0;
            phase_d    = PH_MARK;
            elem_idx_d = '0;
            done_d     = 1'b1;
          end
        endcase
      end else begin
        tick_cnt_d = next_ext[COUNT_WIDTH-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q   <= 1'b0;
      pattern_q  <= '0;
      length_q   <= '0;
      elem_idx_q <= '0;
      phase_q    <= PH_MARK;
      tick_cnt_q <= '0;
      lamp_q     <= 1'b0;
    end else if (in_fire) begin
      active_q   <= active_d;
      pattern_q  <= pattern_d;
      length_q   <= length_d;
      elem_idx_q <= elem_idx_d;
      phase_q    <= phase_d;
      tick_cnt_q <= tick_cnt_d;
      lamp_q     <= lamp_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_data_q <= {done_d, acc_d, active_d, lamp_d};
    end
  end

endmodule

@@ sim/testbench.sv @@
// testbench for the morse code keyer: drives character and tick items through
// several duration settings and idling phases, predicts every status item and
// checks it field by field; depends on mck_pkg and morse_code_keyer
`timescale 1ns / 100ps

module testbench;
  import mck_pkg::*;

  localparam int unsigned COUNT_MAX   = (1 << COUNT_WIDTH_DEFAULT) - 1;
  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned REG_COUNT   = REG_WGAP_TICKS + 1;

  class keyer_scoreboard;
    logic [DUR_WIDTH-1:0] dur [REG_COUNT];
    string                morse [26];
    bit                   active;
    bit                   lamp;
    string                sym;
    int unsigned          elem;
    phase_e               ph;
    int unsigned          count;
    logic [7:0]           status_q [$];
    int unsigned          errors;
    bit                   effective;

    function new();
      morse = '{".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..", ".---",
                "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.", "...", "-",
                "..-", "...-", ".--", "-..-", "-.--", "--.."};
      dur = '{DOT_TICKS_RST, DASH_TICKS_RST, EGAP_TICKS_RST, LGAP_TICKS_RST,
              WGAP_TICKS_RST};
      active = 1'b0;
      lamp   = 1'b0;
      sym    = "";
      elem   = 0;
      ph     = PH_MARK;
      count  = 0;
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_WIDTH-1:0] idx, logic [DUR_WIDTH-1:0] val);
      if (idx <= REG_WGAP_TICKS) begin
        dur[idx] = val;
      end
    endfunction

    function int unsigned phase_ticks();
      int unsigned d;
      case (ph)
        PH_MARK: d = (sym[elem] == "-") ? dur[REG_DASH_TICKS] : dur[REG_DOT_TICKS];
        PH_EGAP: d = dur[REG_EGAP_TICKS];
        PH_LGAP: d = dur[REG_LGAP_TICKS];
        default: d = dur[REG_WGAP_TICKS];
      endcase
      if (d == 0) d = 1;
      if (d > COUNT_MAX) d = COUNT_MAX;
      return d;
    endfunction

    function void note_item(logic op, logic [7:0] ch);
      logic [7:0]  lc;
      bit          acc;
      bit          done;
      int unsigned nxt;
      acc       = 1'b0;
      done      = 1'b0;
      effective = 1'b0;
      if (op == OP_CHAR) begin
        if (!active) begin
          lc = ch;
          if (lc >= CHAR_UPPER_A && lc <= CHAR_UPPER_Z) lc = lc | CASE_BIT;
          if (lc >= CHAR_LOWER_A && lc <= CHAR_LOWER_Z) begin
            sym  = morse[lc - CHAR_LOWER_A];
            ph   = PH_MARK;
            lamp = 1'b1;
            acc  = 1'b1;
          end else if (lc == CHAR_SPACE) begin
            sym  = "";
            ph   = PH_WGAP;
            lamp = 1'b0;
            acc  = 1'b1;
          end
          if (acc) begin
            elem   = 0;
            count  = 0;
            active = 1'b1;
          end
        end
      end else if (active) begin
        effective = 1'b1;
        nxt = count + 1;
        if (nxt >= phase_ticks()) begin
          count = 0;
          case (ph)
            PH_MARK: begin
              lamp = 1'b0;
              ph   = (elem + 1 < sym.len()) ? PH_EGAP : PH_LGAP;
            end
            PH_EGAP: begin
              elem = elem + 1;
              ph   = PH_MARK;
              lamp = 1'b1;
            end
            default: begin
              active = 1'b0;
              lamp   = 1'b0;
              ph     = PH_MARK;
              elem   = 0;
              done   = 1'b1;
            end
          endcase
        end else begin
          count = nxt;
        end
      end
      effective = effective | acc;
      status_q.push_back({4'b0000, done, acc, active, lamp});
    endfunction

    function void check_result(logic [7:0] got);
      logic [7:0] want;
      string      field;
      if (status_q.size() == 0) begin
        $display("%0t: status item %h arrived with nothing expected", $time, got);
        errors++;
        return;
      end
      want = status_q.pop_front();
      for (int i = 0; i < 8; i++) begin
        if (got[i] !== want[i]) begin
          case (i)
            0:       field = "led_on";
            1:       field = "busy_res";
            2:       field = "accepted";
            3:       field = "done_res";
            default: field = "zero fill";
          endcase
          $display("%0t: %s expected %0b got %0b", $time, field, want[i], got[i]);
          errors++;
        end
      end
    endfunction
  endclass

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     s_axis_tvalid_i = 1'b0;
  logic                     s_axis_tready_o;
  logic [7:0]               s_axis_tdata_i = 8'h00;
  logic                     s_axis_tuser_i = OP_TICK;
  logic                     m_axis_tvalid_o;
  logic                     m_axis_tready_i = 1'b0;
  logic [7:0]               m_axis_tdata_o;
  logic                     cfg_we_i = 1'b0;
  logic [CFG_IDX_WIDTH-1:0] cfg_idx_i = REG_DOT_TICKS;
  logic [DUR_WIDTH-1:0]     cfg_data_i = '0;

  keyer_scoreboard sb = new();
  int unsigned     sender_idle_pct = 0;
  int unsigned     rx_stall_pct = 0;
  bit              hold_request = 1'b0;
  int unsigned     hold_left = 0;
  int unsigned     cycles = 0;

  morse_code_keyer dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      sb.check_result(m_axis_tdata_o);
    end
    if (hold_request) begin
      hold_left    = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL morse_code_keyer");
      $finish;
    end
  end

  task automatic push_item(input logic op, input logic [7:0] ch);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= op;
    s_axis_tdata_i  <= ch;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    sb.note_item(op, ch);
  endtask

  task automatic run_out();
    while (sb.active) push_item(OP_TICK, 8'($urandom));
  endtask

  task automatic key_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      push_item(OP_CHAR, s[i]);
      run_out();
    end
  endtask

  task automatic wait_idle();
    s_axis_tvalid_i <= 1'b0;
    while (sb.status_q.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  // the five durations, then one write to an unused index
  task automatic write_regs(input logic [DUR_WIDTH-1:0] v0, v1, v2, v3, v4);
    logic [DUR_WIDTH-1:0]     vals [REG_COUNT];
    logic [CFG_IDX_WIDTH-1:0] idx;
    logic [DUR_WIDTH-1:0]     data;
    vals = '{v0, v1, v2, v3, v4};
    for (int i = 0; i <= REG_COUNT; i++) begin
      if (i < REG_COUNT) begin
        idx  = CFG_IDX_WIDTH'(i);
        data = vals[i];
      end else begin
        idx  = CFG_IDX_WIDTH'($urandom_range((1 << CFG_IDX_WIDTH) - 1, REG_COUNT));
        data = DUR_WIDTH'($urandom);
      end
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= idx;
      cfg_data_i <= data;
      @(posedge clk_i);
      sb.set_reg(idx, data);
    end
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [DUR_WIDTH-1:0] short_dur();
    return ($urandom_range(9) == 0) ? '0 : DUR_WIDTH'($urandom_range(5, 1));
  endfunction

  task automatic random_items(input int unsigned n);
    int unsigned sent;
    int unsigned r;
    logic [7:0]  ch;
    sent = 0;
    while (sent < n) begin
      r = $urandom_range(99);
      if (sb.active) begin
        if (r < 12) push_item(OP_CHAR, 8'($urandom));
        else push_item(OP_TICK, 8'($urandom));
      end else if (r < 8) begin
        push_item(OP_TICK, 8'($urandom));
      end else if (r < 82) begin
        ch = CHAR_UPPER_A + 8'($urandom_range(25));
        if ($urandom_range(1)) ch = ch | CASE_BIT;
        push_item(OP_CHAR, ch);
      end else if (r < 92) begin
        push_item(OP_CHAR, CHAR_SPACE);
      end else begin
        push_item(OP_CHAR, 8'($urandom));
      end
      if (sb.effective) sent++;
    end
    run_out();
  endtask

  initial begin
    logic [7:0]  stray_chars [6];
    int unsigned idle_tab [4];
    int unsigned stall_tab [4];
    logic [7:0]  ch;
    stray_chars = '{CHAR_UPPER_A - 8'd1, CHAR_UPPER_Z + 8'd1, CHAR_LOWER_A - 8'd1,
                    CHAR_LOWER_Z + 8'd1, 8'h00, 8'hFF};
    idle_tab    = '{0, 82, 0, 19};
    stall_tab   = '{0, 0, 82, 19};

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset durations: idle tick, characters outside the table, offer while busy
    push_item(OP_TICK, 8'h5A);
    foreach (stray_chars[i]) push_item(OP_CHAR, stray_chars[i]);
    push_item(OP_CHAR, "E");
    push_item(OP_CHAR, "T");
    run_out();
    key_text(" ");
    wait_idle();

    // shortest durations, every letter in alternating case
    write_regs(16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
    for (int i = 0; i < 26; i++) begin
      ch = CHAR_UPPER_A + 8'(i);
      if (i % 2) ch = ch | CASE_BIT;
      key_text(string'(ch));
    end
    key_text(" ");
    wait_idle();

    // zero durations behave as one tick
    write_regs('0, '0, '0, '0, '0);
    key_text("q ");
    wait_idle();

    for (int m = 0; m < 4; m++) begin
      sender_idle_pct = idle_tab[m];
      rx_stall_pct    = stall_tab[m];
      write_regs(short_dur(), short_dur(), short_dur(), short_dur(), short_dur());
      if (m == 0) hold_request = 1'b1;
      random_items(90);
      wait_idle();
    end

    if (sb.errors == 0) begin
      $display("PASS morse_code_keyer");
    end else begin
      $display("FAIL morse_code_keyer");
    end
    $finish;
  end

endmodule
